/* rtl/core/mts_pkg.sv */
// Package with the shared constants and types of the markup tag scanner.
`default_nettype none
package mts_pkg;

  localparam int unsigned POSITION_BITS = 32;
  localparam int unsigned SUM_BITS      = 32;
  localparam int unsigned OUT_W         = 32;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned STEP_W        = $clog2(SUM_BITS);
  localparam int unsigned PADDR_W       = 3;

  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SL    = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  localparam logic REG_FOLD_CASE = 1'b0;

  localparam logic KIND_END = 1'b0;
  localparam logic KIND_TAG = 1'b1;

  typedef struct packed {
    logic                     has_tag;
    logic                     has_end;
    logic [SUM_BITS-1:0]      sum;
    logic [BYTE_W-1:0]        divisor;
    logic [POSITION_BITS-1:0] begin_pos;
    logic [POSITION_BITS-1:0] end_pos;
    logic                     closing;
  } mts_job_t;

endpackage
`default_nettype wire

/* rtl/core/mts_in_if.sv */
// Interface of the input byte channel.
`default_nettype none
interface mts_in_if;
  import mts_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* rtl/core/mts_out_if.sv */
// Interface of the output record channel.
`default_nettype none
interface mts_out_if;
  import mts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    record_kind;
  logic signed [OUT_W-1:0] tag_code;
  logic [OUT_W-1:0]        begin_pos;
  logic [OUT_W-1:0]        end_pos;
  logic                    is_closing;
  logic                    last_record;

  modport source (output valid, output record_kind, output tag_code, output begin_pos,
                  output end_pos, output is_closing, output last_record, input ready);
  modport sink (input valid, input record_kind, input tag_code, input begin_pos,
                input end_pos, input is_closing, input last_record, output ready);
endinterface
`default_nettype wire

/* rtl/core/markup_tag_scanner.sv */
// Top level of the markup tag scanner with its register port.
`default_nettype none
// The scanner takes one document byte per cycle and queues a job for every
// closed tag and for the last byte. Each tag record then passes through the
// record builder's divider, which produces one quotient bit per cycle, then
// through a sign fixup state and the handoff; an end record goes straight to
// its handoff. The job queue holds four jobs, so short bursts of tags pass at
// the byte rate and the input stalls only while the queue is full.
// The fold_case register sits at address 0 and should be written only while
// the block is idle.
module markup_tag_scanner
  import mts_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  mts_in_if.sink                  byte_i,
  mts_out_if.source               rec_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic     fold_case_q, fold_case_d;
  mts_job_t front_job, back_job;
  logic     front_valid, front_ready, back_valid, back_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FOLD_CASE) ? {31'b0, fold_case_q} : '0;

  always_comb begin
    fold_case_d = fold_case_q;
    if (psel && penable && pwrite && (paddr[2] == REG_FOLD_CASE)) begin
      fold_case_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_case_q <= 1'b1;
    end else begin
      fold_case_q <= fold_case_d;
    end
  end

  mts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fold_case_i (fold_case_q),
    .byte_i      (byte_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  mts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_job_o    (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  mts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .rec_o       (rec_o)
  );

`ifndef SYNTHESIS
  a_kind_vs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_o.valid |-> (rec_o.record_kind != rec_o.last_record))
    else $error("record kind and last flag disagree");

  a_end_record_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && !rec_o.record_kind) |->
      ((rec_o.tag_code == -1) && (rec_o.begin_pos == '1) && (rec_o.end_pos == '1)
       && !rec_o.is_closing))
    else $error("end record carries wrong fields");

  a_tag_then_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_valid && back_ready && back_job.has_tag) |=> !rec_o.valid)
    else $error("tag record shown before its code was computed");
`endif

endmodule
`default_nettype wire

/* rtl/core/mts_front.sv */
// Byte scanner that tracks tag state and issues tag and end jobs.
`default_nettype none
module mts_front
  import mts_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fold_case_i,
  mts_in_if.sink     byte_i,
  output mts_job_t   job_o,
  output logic       job_valid_o,
  input  wire logic  job_ready_i
);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     in_tag_q, in_tag_d;
  logic                     collect_q, collect_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [SUM_BITS-1:0]      sum_q, sum_d;
  logic [1:0]               name_len_q, name_len_d;
  logic [BYTE_W-1:0]        second_q, second_d;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] sec;
  logic              emit_tag;

  assign byte_i.ready = job_ready_i;
  assign accept = byte_i.valid && job_ready_i;

  always_comb begin
    b = byte_i.data_byte;
    if (fold_case_i && (b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
      b = b + CASE_OFFSET;
    end
  end

  assign sec = (name_len_q >= 2'd2) ? second_q : b;

  always_comb begin
    pos_d      = pos_q;
    in_tag_d   = in_tag_q;
    collect_d  = collect_q;
    start_d    = start_q;
    sum_d      = sum_q;
    name_len_d = name_len_q;
    second_d   = second_q;
    emit_tag   = 1'b0;
    if (accept) begin
      if (!in_tag_q) begin
        if (b == CH_LT) begin
          in_tag_d   = 1'b1;
          collect_d  = 1'b1;
          start_d    = pos_q;
          sum_d      = '1 + SUM_BITS'(CH_LT);
          name_len_d = 2'd1;
          second_d   = '0;
        end
      end else if (b == CH_GT) begin
        emit_tag   = 1'b1;
        in_tag_d   = 1'b0;
        collect_d  = 1'b0;
        start_d    = '0;
        sum_d      = '1;
        name_len_d = 2'd0;
        second_d   = '0;
      end else if (collect_q) begin
        if (b == CH_SP) begin
          collect_d = 1'b0;
        end else begin
          sum_d = sum_q + SUM_BITS'(b);
          if (name_len_q == 2'd1) begin
            second_d   = b;
            name_len_d = 2'd2;
          end
        end
      end else if (b == CH_LT) begin
        collect_d = 1'b1;
      end
      pos_d = pos_q + 1'b1;
      if (byte_i.last_byte) begin
        pos_d      = '0;
        in_tag_d   = 1'b0;
        collect_d  = 1'b0;
        start_d    = '0;
        sum_d      = '1;
        name_len_d = 2'd0;
        second_d   = '0;
      end
    end
  end

  always_comb begin
    job_o.has_tag   = emit_tag;
    job_o.has_end   = byte_i.last_byte;
    job_o.sum       = sum_q + SUM_BITS'(CH_GT);
    job_o.divisor   = (sec == '0) ? BYTE_W'(1) : sec;
    job_o.begin_pos = start_q;
    job_o.end_pos   = pos_q;
    job_o.closing   = (sec == CH_SL);
  end

  assign job_valid_o = accept && (emit_tag || byte_i.last_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      in_tag_q   <= 1'b0;
      collect_q  <= 1'b0;
      start_q    <= '0;
      sum_q      <= '1;
      name_len_q <= 2'd0;
      second_q   <= '0;
    end else begin
      pos_q      <= pos_d;
      in_tag_q   <= in_tag_d;
      collect_q  <= collect_d;
      start_q    <= start_d;
      sum_q      <= sum_d;
      name_len_q <= name_len_d;
      second_q   <= second_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mts_queue.sv */
// Short job queue between the scanner and the record builder.
`default_nettype none
module mts_queue
  import mts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire mts_job_t  push_job_i,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  output mts_job_t       pop_job_o,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i
);

  mts_job_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_job_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mts_back.sv */
// Record builder with a bit-serial divider for the tag code.
`default_nettype none
module mts_back
  import mts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire mts_job_t  job_i,
  input  wire logic      job_valid_i,
  output logic           job_ready_o,
  mts_out_if.source      rec_o
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_DIVIDE  = 5'b00010,
    ST_FIXUP   = 5'b00100,
    ST_TAG_OUT = 5'b01000,
    ST_END_OUT = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  mts_job_t            job_q;
  logic [SUM_BITS-1:0] quo_q, quo_d;
  logic [BYTE_W-1:0]   rem_q, rem_d;
  logic                neg_q;
  logic [STEP_W-1:0]   step_q;
  logic [SUM_BITS-1:0] code_q;
  logic [BYTE_W:0]     trial;
  logic                fits;
  logic [SUM_BITS-1:0] signed_quo;

  assign trial = {rem_q, quo_q[SUM_BITS-1]};
  assign fits  = (trial >= {1'b0, job_q.divisor});
  assign rem_d = fits ? BYTE_W'(trial - {1'b0, job_q.divisor}) : BYTE_W'(trial);
  assign quo_d = {quo_q[SUM_BITS-2:0], fits};
  assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;

  assign job_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.has_tag ? ST_DIVIDE : ST_END_OUT;
        end
      end
      ST_DIVIDE: begin
        if (step_q == STEP_W'(SUM_BITS - 1)) begin
          state_d = ST_FIXUP;
        end
      end
      ST_FIXUP: begin
        state_d = ST_TAG_OUT;
      end
      ST_TAG_OUT: begin
        if (rec_o.ready) begin
          state_d = job_q.has_end ? ST_END_OUT : ST_IDLE;
        end
      end
      ST_END_OUT: begin
        if (rec_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && job_valid_i) begin
      job_q  <= job_i;
      neg_q  <= job_i.sum[SUM_BITS-1];
      quo_q  <= job_i.sum[SUM_BITS-1] ? (~job_i.sum + 1'b1) : job_i.sum;
      rem_q  <= '0;
      step_q <= '0;
    end else if (state_q == ST_DIVIDE) begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      step_q <= step_q + 1'b1;
    end
    if (state_q == ST_FIXUP) begin
      code_q <= signed_quo + SUM_BITS'(job_q.divisor);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    rec_o.valid       = (state_q == ST_TAG_OUT) || (state_q == ST_END_OUT);
    rec_o.record_kind = (state_q == ST_TAG_OUT) ? KIND_TAG : KIND_END;
    rec_o.last_record = (state_q == ST_END_OUT);
    if (state_q == ST_TAG_OUT) begin
      rec_o.tag_code   = signed'(OUT_W'(code_q));
      rec_o.begin_pos  = OUT_W'(job_q.begin_pos);
      rec_o.end_pos    = OUT_W'(job_q.end_pos);
      rec_o.is_closing = job_q.closing;
    end else begin
      rec_o.tag_code   = '1;
      rec_o.begin_pos  = '1;
      rec_o.end_pos    = '1;
      rec_o.is_closing = 1'b0;
    end
  end

endmodule
`default_nettype wire
